// File: src/rfs_pkg.sv
// Shared constants, types and codes of the range fetch scheduler.
`timescale 1ns / 1ps
`default_nettype none
package rfs_pkg;

   localparam int MaxRanges  = 16;
   localparam int SlotW      = $clog2(MaxRanges);
   localparam int CntW       = $clog2(MaxRanges + 1);
   localparam int IdxW       = 16;
   localparam int ValW       = IdxW + 3;
   localparam int ItemHeight = 70;
   localparam int SpW        = 22;
   localparam int BatchW     = 11;
   localparam int BatchReset = 100;
   localparam int FuncW      = 3;

   // The focus index is the scroll position times the rounded-up reciprocal of the
   // item height, shifted down; this is exact for every scroll position of SpW bits.
   localparam int FocusShift = SpW + $clog2(ItemHeight);
   localparam logic [SpW:0] FocusMul =
      (SpW + 1)'(((longint'(1) <<< FocusShift) + ItemHeight - 1) / ItemHeight);

   typedef logic [IdxW-1:0]        idx_type;
   typedef logic signed [ValW-1:0] val_type;

   localparam val_type IdxMax = {3'b000, {IdxW{1'b1}}};

   localparam logic [FuncW-1:0] FuncRequest  = 3'd0;
   localparam logic [FuncW-1:0] FuncComplete = 3'd1;
   localparam logic [FuncW-1:0] FuncInsert   = 3'd2;
   localparam logic [FuncW-1:0] FuncRemove   = 3'd3;
   localparam logic [FuncW-1:0] FuncFocus    = 3'd4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_MERGE,
      ST_ADD,
      ST_FIND,
      ST_EDIT,
      ST_RESTART,
      ST_SC_DIST,
      ST_SC_CUT,
      ST_SC_POOL,
      ST_SC_SPLIT,
      ST_SC_TRACK,
      ST_FINISH
   } state_type;

   function automatic val_type widen(idx_type v);
      return {3'b000, v};
   endfunction

endpackage
`default_nettype wire

// File: src/rfs_if.sv
// Request and result channel interfaces of the range fetch scheduler.
`timescale 1ns / 1ps
`default_nettype none
interface rfs_req_if;
   logic                   valid;
   logic                   ready;
   logic [2:0]             func;
   logic [15:0]            range_first;
   logic signed [16:0]     range_last;
   logic [15:0]            list_size;
   logic [15:0]            edit_start;
   logic [15:0]            edit_count;
   logic [21:0]            scroll_position;

   modport source (output valid, func, range_first, range_last, list_size, edit_start,
                   edit_count, scroll_position, input ready);
   modport sink (input valid, func, range_first, range_last, list_size, edit_start,
                 edit_count, scroll_position, output ready);
endinterface

interface rfs_rsp_if;
   logic        valid;
   logic        ready;
   logic        fetch_issue;
   logic [15:0] fetch_first;
   logic [15:0] fetch_last;
   logic        fetch_cancel;
   logic        table_full;

   modport source (output valid, fetch_issue, fetch_first, fetch_last, fetch_cancel,
                   table_full, input ready);
   modport sink (input valid, fetch_issue, fetch_first, fetch_last, fetch_cancel,
                 table_full, output ready);
endinterface
`default_nettype wire

// File: src/range_fetch_scheduler.sv
// Top level of the range fetch scheduler: range table, sequencer and shared datapath.
// The block takes one event word at a time on req_ch: a range request, a fetch
// completion, an insert or remove edit of the list, or a new scroll position.
// For every event it returns exactly one result word on rsp_ch, which may carry
// a newly issued fetch batch, a cancel of the fetch in flight and a table-full flag.
// The batch size is written through the APB port at any address below four.
// Each event walks the range table one entry per cycle through a single read port
// and a single adder and compare unit. A request is merged into the table and, when
// scheduling, a batch is then chosen; the table holds at most 16 entries. An edit
// walks the table, plus a merge and a schedule when it hits the fetch in flight.
// A scroll position is turned into the focus index by a multiplication with the
// reciprocal of the item height.
// req_ch.ready is high only while the sequencer is idle.
// The finished result is held in an output register; the next event is accepted
// while that word waits, and the sequencer stalls at its end only if the previous
// result has still not been taken.
// Synchronous reset empties the table, clears the fetch in flight and the focus,
// and sets the batch size to 100.
`timescale 1ns / 1ps
`default_nettype none
module range_fetch_scheduler (
   input  wire logic        clock,
   input  wire logic        reset,
   rfs_req_if.sink          req_ch,
   rfs_rsp_if.source        rsp_ch,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   localparam int N     = rfs_pkg::MaxRanges;
   localparam int SlotW = rfs_pkg::SlotW;
   localparam int CntW  = rfs_pkg::CntW;
   localparam int IdxW  = rfs_pkg::IdxW;
   localparam int SpW   = rfs_pkg::SpW;

   rfs_pkg::state_type state_ff, state_in;

   logic [N-1:0]          valid_ff;
   rfs_pkg::idx_type      first_ff [N];
   rfs_pkg::idx_type      last_ff  [N];
   logic [SlotW-1:0]      order_ff [N];
   logic [CntW-1:0]       count_ff;

   logic [rfs_pkg::FuncW-1:0] func_ff, func_in;
   rfs_pkg::idx_type      es_ff, es_in, ec_ff, ec_in;
   logic [SpW-1:0]        sp_ff, sp_in;
   rfs_pkg::val_type      f_ff, f_in, l_ff, l_in, pool_ff, pool_in, bdist_ff, bdist_in;
   logic [CntW-1:0]       pos_ff, pos_in;
   logic [SlotW-1:0]      bpos_ff, bpos_in;
   logic                  busy_ff, busy_in, held_ff, held_in, hit_ff, hit_in;
   logic                  restart_ff, restart_in;
   logic [SlotW-1:0]      inflight_ff, inflight_in;
   rfs_pkg::idx_type      focus_ff, focus_in;
   logic [rfs_pkg::BatchW-1:0] batch_ff;
   logic                  o_issue_ff, o_issue_in, o_cancel_ff, o_cancel_in;
   logic                  o_full_ff, o_full_in;
   rfs_pkg::idx_type      o_first_ff, o_first_in, o_last_ff, o_last_in;
   logic                  rsp_valid_ff, rsp_issue_ff, rsp_cancel_ff, rsp_full_ff;
   rfs_pkg::idx_type      rsp_first_ff, rsp_last_ff;

   logic                  req_accept, rsp_free, pos_lt, find_hit, req_ok;
   logic [SlotW-1:0]      rd_slot, free_slot, drop_pos;
   logic                  free_found;
   rfs_pkg::val_type      ef, el, rl_w, rl_clamped, bv, lo, hi, t_lo, t_hi;
   rfs_pkg::val_type      mid_sum, dd, adist, endv, nl, nf, amt;
   logic                  drop_en, add_en, wr_en;
   rfs_pkg::val_type      add_first, add_last, wr_first, wr_last;
   logic [2*SpW:0]        focus_prod;
   logic [SpW-1:0]        focus_q;

   assign req_accept = req_ch.valid && req_ch.ready;
   assign rsp_free   = !rsp_valid_ff || rsp_ch.ready;
   assign pos_lt     = pos_ff < count_ff;
   assign find_hit   = pos_lt && (rd_slot == inflight_ff);

   always_comb begin
      case (state_ff) inside
         rfs_pkg::ST_SC_CUT, rfs_pkg::ST_SC_POOL, rfs_pkg::ST_SC_SPLIT: rd_slot = order_ff[bpos_ff];
         rfs_pkg::ST_RESTART: rd_slot = inflight_ff;
         default:             rd_slot = order_ff[pos_ff[SlotW-1:0]];
      endcase
   end

   assign ef = rfs_pkg::widen(first_ff[rd_slot]);
   assign el = rfs_pkg::widen(last_ff[rd_slot]);

   always_comb begin
      free_found = 1'b0;
      free_slot  = '0;
      for (int i = N - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_found = 1'b1;
            free_slot  = SlotW'(i);
         end
      end
   end

   assign rl_w = {{(rfs_pkg::ValW - 17){req_ch.range_last[16]}}, req_ch.range_last};
   assign rl_clamped = (rl_w < 0 || rl_w >= rfs_pkg::widen(req_ch.list_size)) ?
                       rfs_pkg::widen(req_ch.list_size) - rfs_pkg::val_type'(1) : rl_w;
   assign req_ok = rl_clamped >= rfs_pkg::widen(req_ch.range_first);

   assign mid_sum = (ef + el) >>> 1;
   assign dd      = rfs_pkg::widen(focus_ff) - mid_sum;
   assign adist   = (dd < 0) ? -dd : dd;
   assign bv      = (batch_ff == '0) ? rfs_pkg::val_type'(1)
                                     : {{(rfs_pkg::ValW - rfs_pkg::BatchW){1'b0}}, batch_ff};
   assign lo      = rfs_pkg::widen(focus_ff) - ((bv - rfs_pkg::val_type'(1)) >>> 1);
   assign hi      = rfs_pkg::widen(focus_ff) + (bv >>> 1);
   assign t_lo    = (lo > el) ? el : lo;
   assign t_hi    = (hi > el) ? el : hi;
   assign nl      = (l_ff + pool_ff < el) ? l_ff + pool_ff : el;
   assign nf      = (f_ff - pool_ff > ef) ? f_ff - pool_ff : ef;
   assign amt     = rfs_pkg::widen(ec_ff);
   assign endv    = rfs_pkg::widen(es_ff) + amt;
   assign focus_prod = sp_ff * rfs_pkg::FocusMul;
   assign focus_q    = SpW'(focus_prod >> rfs_pkg::FocusShift);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rfs_pkg::ST_IDLE: begin
            if (req_accept) begin
               case (req_ch.func) inside
                  rfs_pkg::FuncRequest:  state_in = req_ok ? rfs_pkg::ST_MERGE
                                                          : rfs_pkg::ST_FINISH;
                  rfs_pkg::FuncComplete: state_in = !busy_ff ? rfs_pkg::ST_FINISH :
                                                    held_ff ? rfs_pkg::ST_FIND
                                                            : rfs_pkg::ST_SC_DIST;
                  rfs_pkg::FuncInsert, rfs_pkg::FuncRemove: state_in = rfs_pkg::ST_EDIT;
                  rfs_pkg::FuncFocus:    state_in = rfs_pkg::ST_DIV;
                  default:               state_in = rfs_pkg::ST_FINISH;
               endcase
            end
         end
         rfs_pkg::ST_DIV: begin
            state_in = rfs_pkg::ST_FINISH;
         end
         rfs_pkg::ST_MERGE: begin
            if (!pos_lt) state_in = rfs_pkg::ST_ADD;
         end
         rfs_pkg::ST_ADD: begin
            state_in = busy_ff ? rfs_pkg::ST_FINISH : rfs_pkg::ST_SC_DIST;
         end
         rfs_pkg::ST_FIND: begin
            if (find_hit || !pos_lt) begin
               state_in = restart_ff ? rfs_pkg::ST_MERGE : rfs_pkg::ST_SC_DIST;
            end
         end
         rfs_pkg::ST_EDIT: begin
            if (!pos_lt) state_in = hit_ff ? rfs_pkg::ST_RESTART : rfs_pkg::ST_FINISH;
         end
         rfs_pkg::ST_RESTART: begin
            state_in = (busy_ff && held_ff) ? rfs_pkg::ST_FIND : rfs_pkg::ST_SC_DIST;
         end
         rfs_pkg::ST_SC_DIST: begin
            if (count_ff == '0) begin
               state_in = rfs_pkg::ST_FINISH;
            end else if (pos_ff == count_ff - CntW'(1)) begin
               state_in = rfs_pkg::ST_SC_CUT;
            end
         end
         rfs_pkg::ST_SC_CUT:   state_in = rfs_pkg::ST_SC_POOL;
         rfs_pkg::ST_SC_POOL:  state_in = rfs_pkg::ST_SC_SPLIT;
         rfs_pkg::ST_SC_SPLIT: state_in = rfs_pkg::ST_SC_TRACK;
         rfs_pkg::ST_SC_TRACK: state_in = rfs_pkg::ST_FINISH;
         rfs_pkg::ST_FINISH: begin
            if (rsp_free) state_in = rfs_pkg::ST_IDLE;
         end
         default: state_in = rfs_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      func_in = func_ff;   es_in = es_ff;       ec_in = ec_ff;     sp_in = sp_ff;
      f_in = f_ff;         l_in = l_ff;         pool_in = pool_ff; bdist_in = bdist_ff;
      pos_in = pos_ff;     bpos_in = bpos_ff;   busy_in = busy_ff; held_in = held_ff;
      hit_in = hit_ff;     restart_in = restart_ff;
      inflight_in = inflight_ff;                focus_in = focus_ff;
      o_issue_in = o_issue_ff;   o_cancel_in = o_cancel_ff;   o_full_in = o_full_ff;
      o_first_in = o_first_ff;   o_last_in = o_last_ff;
      drop_en = 1'b0;  add_en = 1'b0;  wr_en = 1'b0;
      drop_pos = pos_ff[SlotW-1:0];
      add_first = f_ff;  add_last = l_ff;  wr_first = ef;  wr_last = el;
      unique case (state_ff)
         rfs_pkg::ST_IDLE: begin
            if (req_accept) begin
               func_in = req_ch.func;
               es_in = req_ch.edit_start;
               ec_in = req_ch.edit_count;
               sp_in = req_ch.scroll_position;
               pos_in = '0;  hit_in = 1'b0;  restart_in = 1'b0;
               o_issue_in = 1'b0;  o_cancel_in = 1'b0;  o_full_in = 1'b0;
               o_first_in = '0;  o_last_in = '0;
               f_in = rfs_pkg::widen(req_ch.range_first);
               l_in = rl_clamped;
               if (req_ch.func == rfs_pkg::FuncComplete) busy_in = 1'b0;
            end
         end
         rfs_pkg::ST_DIV: begin
            focus_in = (focus_q > SpW'({IdxW{1'b1}})) ? {IdxW{1'b1}} : IdxW'(focus_q);
         end
         rfs_pkg::ST_MERGE: begin
            if (pos_lt) begin
               if (held_ff && rd_slot == inflight_ff) begin
                  pos_in = pos_ff + CntW'(1);
               end else if (f_ff <= ef && l_ff >= el) begin
                  drop_en = 1'b1;
               end else if (f_ff >= ef && l_ff <= el) begin
                  f_in = ef;  l_in = el;  drop_en = 1'b1;
               end else if (f_ff < ef && l_ff >= ef) begin
                  l_in = el;  drop_en = 1'b1;
               end else if (l_ff > el && f_ff <= el) begin
                  f_in = ef;  drop_en = 1'b1;
               end else begin
                  pos_in = pos_ff + CntW'(1);
               end
            end
         end
         rfs_pkg::ST_ADD: begin
            add_en = 1'b1;
            pos_in = '0;
         end
         rfs_pkg::ST_FIND: begin
            if (find_hit) begin
               drop_en = 1'b1;
               held_in = 1'b0;
               pos_in = '0;
            end else if (pos_lt) begin
               pos_in = pos_ff + CntW'(1);
            end else begin
               held_in = 1'b0;
               pos_in = '0;
            end
         end
         rfs_pkg::ST_EDIT: begin
            if (pos_lt) begin
               pos_in = pos_ff + CntW'(1);
               if (func_ff == rfs_pkg::FuncInsert) begin
                  if (ef >= rfs_pkg::widen(es_ff)) begin
                     if (held_ff && rd_slot == inflight_ff) hit_in = 1'b1;
                     wr_en = 1'b1;
                     wr_first = (ef + amt > rfs_pkg::IdxMax) ? rfs_pkg::IdxMax : ef + amt;
                     wr_last  = (el + amt > rfs_pkg::IdxMax) ? rfs_pkg::IdxMax : el + amt;
                  end else if (el >= rfs_pkg::widen(es_ff)) begin
                     if (held_ff && rd_slot == inflight_ff) hit_in = 1'b1;
                     wr_en = 1'b1;
                     wr_last  = (el + amt > rfs_pkg::IdxMax) ? rfs_pkg::IdxMax : el + amt;
                  end
               end else begin
                  if (ef >= rfs_pkg::widen(es_ff)) begin
                     if (held_ff && rd_slot == inflight_ff) hit_in = 1'b1;
                     if (ef >= endv) begin
                        wr_en = 1'b1;  wr_first = ef - amt;  wr_last = el - amt;
                     end else if (el < endv) begin
                        drop_en = 1'b1;
                        pos_in = pos_ff;
                     end else begin
                        wr_en = 1'b1;  wr_first = rfs_pkg::widen(es_ff);  wr_last = el - amt;
                     end
                  end else if (el >= endv) begin
                     if (held_ff && rd_slot == inflight_ff) hit_in = 1'b1;
                     wr_en = 1'b1;  wr_last = el - amt;
                  end else if (el >= rfs_pkg::widen(es_ff)) begin
                     if (held_ff && rd_slot == inflight_ff) hit_in = 1'b1;
                     wr_en = 1'b1;  wr_last = rfs_pkg::widen(es_ff) - rfs_pkg::val_type'(1);
                  end
               end
            end
         end
         rfs_pkg::ST_RESTART: begin
            pos_in = '0;
            if (busy_ff) begin
               o_cancel_in = 1'b1;
               busy_in = 1'b0;
               if (held_ff) begin
                  f_in = ef;  l_in = el;  restart_in = 1'b1;
               end
            end
         end
         rfs_pkg::ST_SC_DIST: begin
            if (count_ff != '0) begin
               if (pos_ff == '0 || adist < bdist_ff) begin
                  bdist_in = adist;
                  bpos_in = pos_ff[SlotW-1:0];
               end
               pos_in = pos_ff + CntW'(1);
            end
         end
         rfs_pkg::ST_SC_CUT: begin
            f_in = (t_lo < ef) ? ef : t_lo;
            l_in = (t_hi < ef) ? ef : t_hi;
         end
         rfs_pkg::ST_SC_POOL: begin
            pool_in = bv - (rfs_pkg::val_type'(1) + l_ff - f_ff);
         end
         rfs_pkg::ST_SC_SPLIT: begin
            drop_pos = bpos_ff;
            busy_in = 1'b1;
            if (f_ff == ef) begin
               l_in = nl;
               if (nl == el) drop_en = 1'b1;
               else begin
                  wr_en = 1'b1;  wr_first = nl + rfs_pkg::val_type'(1);
               end
            end else if (l_ff == el) begin
               f_in = nf;
               if (nf == ef) drop_en = 1'b1;
               else begin
                  wr_en = 1'b1;  wr_last = nf - rfs_pkg::val_type'(1);
               end
            end else begin
               add_en = 1'b1;
               add_first = l_ff + rfs_pkg::val_type'(1);
               add_last = el;
               wr_en = 1'b1;
               wr_last = f_ff - rfs_pkg::val_type'(1);
            end
         end
         rfs_pkg::ST_SC_TRACK: begin
            add_en = 1'b1;
            o_issue_in = 1'b1;
            o_first_in = f_ff[IdxW-1:0];
            o_last_in = l_ff[IdxW-1:0];
            if (free_found) begin
               inflight_in = free_slot;
               held_in = 1'b1;
            end
         end
         rfs_pkg::ST_FINISH: begin
         end
         default: begin
         end
      endcase
      if (drop_en && rd_slot == inflight_ff) held_in = 1'b0;
      if (add_en && !free_found) o_full_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
      end else begin
         if (drop_en) begin
            valid_ff[rd_slot] <= 1'b0;
            for (int i = 0; i < N - 1; i++) begin
               if (SlotW'(i) >= drop_pos) order_ff[i] <= order_ff[i+1];
            end
            count_ff <= count_ff - CntW'(1);
         end
         if (add_en && free_found) begin
            valid_ff[free_slot] <= 1'b1;
            first_ff[free_slot] <= add_first[IdxW-1:0];
            last_ff[free_slot] <= add_last[IdxW-1:0];
            order_ff[count_ff[SlotW-1:0]] <= free_slot;
            count_ff <= count_ff + CntW'(1);
         end
         if (wr_en) begin
            first_ff[rd_slot] <= wr_first[IdxW-1:0];
            last_ff[rd_slot] <= wr_last[IdxW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rfs_pkg::ST_IDLE;
         busy_ff <= 1'b0;
         held_ff <= 1'b0;
         inflight_ff <= '0;
         focus_ff <= '0;
         rsp_valid_ff <= 1'b0;
         batch_ff <= rfs_pkg::BatchW'(rfs_pkg::BatchReset);
      end else begin
         state_ff <= state_in;
         busy_ff <= busy_in;
         held_ff <= held_in;
         inflight_ff <= inflight_in;
         focus_ff <= focus_in;
         if (psel && penable && pwrite && !paddr[2]) batch_ff <= pwdata[rfs_pkg::BatchW-1:0];
         if (state_ff == rfs_pkg::ST_FINISH && rsp_free) rsp_valid_ff <= 1'b1;
         else if (rsp_ch.ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      func_ff <= func_in;   es_ff <= es_in;     ec_ff <= ec_in;     sp_ff <= sp_in;
      f_ff <= f_in;         l_ff <= l_in;       pool_ff <= pool_in; bdist_ff <= bdist_in;
      pos_ff <= pos_in;     bpos_ff <= bpos_in; hit_ff <= hit_in;   restart_ff <= restart_in;
      o_issue_ff <= o_issue_in;   o_cancel_ff <= o_cancel_in;   o_full_ff <= o_full_in;
      o_first_ff <= o_first_in;   o_last_ff <= o_last_in;
      if (state_ff == rfs_pkg::ST_FINISH && rsp_free) begin
         rsp_issue_ff <= o_issue_ff;
         rsp_first_ff <= o_first_ff;
         rsp_last_ff <= o_last_ff;
         rsp_cancel_ff <= o_cancel_ff;
         rsp_full_ff <= o_full_ff;
      end
   end

   always_comb begin
      req_ch.ready = (state_ff == rfs_pkg::ST_IDLE);
      rsp_ch.valid = rsp_valid_ff;
      rsp_ch.fetch_issue = rsp_issue_ff;
      rsp_ch.fetch_first = rsp_first_ff;
      rsp_ch.fetch_last = rsp_last_ff;
      rsp_ch.fetch_cancel = rsp_cancel_ff;
      rsp_ch.table_full = rsp_full_ff;
      pready = 1'b1;
      prdata = paddr[2] ? 32'd0 : {{(32 - rfs_pkg::BatchW){1'b0}}, batch_ff};
   end

endmodule
`default_nettype wire

// File: src/rfs_checker.sv
// Port-level checker of the range fetch scheduler and its bind statement.
`timescale 1ns / 1ps
`default_nettype none
module rfs_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        rsp_issue,
   input wire logic [15:0] rsp_first,
   input wire logic [15:0] rsp_last
);

   // A word that is offered and not taken must stay offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word withdrawn while stalled");

   // The block works on one event at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while an event is in progress");

   // Fetch bounds are only meaningful when a fetch is issued.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_issue |-> rsp_first == 16'd0 && rsp_last == 16'd0)
      else $error("fetch bounds set without an issued fetch");

   // An issued batch never runs backwards.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_issue |-> rsp_first <= rsp_last)
      else $error("issued batch with first beyond last");

endmodule

bind range_fetch_scheduler rfs_checker u_rfs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_issue (rsp_ch.fetch_issue),
   .rsp_first (rsp_ch.fetch_first),
   .rsp_last  (rsp_ch.fetch_last)
);
`default_nettype wire

// File: verif/tb_range_fetch_scheduler.sv
// Self-checking testbench of the range fetch scheduler with a behavioural predictor.
`timescale 1ns / 1ps
module tb_range_fetch_scheduler;

   typedef struct packed {
      logic [2:0]         func;
      logic [15:0]        range_first;
      logic signed [16:0] range_last;
      logic [15:0]        list_size;
      logic [15:0]        edit_start;
      logic [15:0]        edit_count;
      logic [21:0]        scroll_position;
   } event_word_type;

   typedef struct packed {
      logic        fetch_issue;
      logic [15:0] fetch_first;
      logic [15:0] fetch_last;
      logic        fetch_cancel;
      logic        table_full;
   } fetch_word_type;

   typedef struct {
      event_word_type ev;
      bit             known;
      fetch_word_type res;
   } stim_row_type;

   localparam longint IndexTop = 65535;
   localparam int     StallLimit = 5000;
   localparam int     RunsOfRandom = 280;

   logic        clock;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   rfs_req_if req_ch ();
   rfs_rsp_if rsp_ch ();

   range_fetch_scheduler u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // Predictor state.
   bit          slot_valid [rfs_pkg::MaxRanges];
   longint      slot_first [rfs_pkg::MaxRanges];
   longint      slot_last [rfs_pkg::MaxRanges];
   int          age_order [rfs_pkg::MaxRanges];
   int          age_count;
   int          flight_slot;
   bit          flight_held;
   bit          flight_busy;
   longint      focus;
   int          batch_len;
   bit          p_issue;
   bit          p_cancel;
   bit          p_full;
   longint      p_first;
   longint      p_last;

   fetch_word_type expected_fetches [$];
   int          err_count;
   int          idle_cycles;
   bit          long_hold_done;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic void drop_at(int pos);
      int slot;
      slot = age_order[pos];
      slot_valid[slot] = 1'b0;
      if (slot == flight_slot) flight_held = 1'b0;
      for (int i = pos; i < age_count - 1; i++) age_order[i] = age_order[i + 1];
      age_count--;
   endfunction

   function automatic int find_age(int slot);
      for (int p = 0; p < age_count; p++) if (age_order[p] == slot) return p;
      return -1;
   endfunction

   function automatic int claim_slot(longint f, longint l);
      for (int s = 0; s < rfs_pkg::MaxRanges; s++) begin
         if (!slot_valid[s]) begin
            slot_valid[s] = 1'b1;
            slot_first[s] = f;
            slot_last[s] = l;
            age_order[age_count] = s;
            age_count++;
            return s;
         end
      end
      p_full = 1'b1;
      return -1;
   endfunction

   function automatic void merge_range(longint f, longint l);
      int pos;
      int s;
      int dummy;
      pos = 0;
      while (pos < age_count) begin
         s = age_order[pos];
         if (flight_held && s == flight_slot) pos++;
         else if (f <= slot_first[s] && l >= slot_last[s]) drop_at(pos);
         else if (f >= slot_first[s] && l <= slot_last[s]) begin
            f = slot_first[s];
            l = slot_last[s];
            drop_at(pos);
         end else if (f < slot_first[s] && l >= slot_first[s]) begin
            l = slot_last[s];
            drop_at(pos);
         end else if (l > slot_last[s] && f <= slot_last[s]) begin
            f = slot_first[s];
            drop_at(pos);
         end else pos++;
      end
      dummy = claim_slot(f, l);
   endfunction

   function automatic longint dist_to_focus(int s);
      longint d;
      d = focus - (slot_first[s] + slot_last[s]) / 2;
      return d < 0 ? -d : d;
   endfunction

   function automatic longint clip(longint lo, longint v, longint hi);
      if (v > hi) v = hi;
      if (v < lo) v = lo;
      return v;
   endfunction

   function automatic void pick_batch();
      int     bpos;
      int     bs;
      int     s;
      longint b;
      longint f;
      longint l;
      longint pool;
      longint bf;
      longint bl;
      if (age_count == 0) return;
      bpos = 0;
      for (int p = 1; p < age_count; p++)
         if (dist_to_focus(age_order[p]) < dist_to_focus(age_order[bpos])) bpos = p;
      bs = age_order[bpos];
      bf = slot_first[bs];
      bl = slot_last[bs];
      b = (batch_len != 0) ? batch_len : 1;
      f = clip(bf, focus - (b - 1) / 2, bl);
      l = clip(bf, focus + b / 2, bl);
      pool = b - (1 + l - f);
      if (f == bf) begin
         l = (l + pool < bl) ? l + pool : bl;
         if (l == bl) drop_at(bpos);
         else slot_first[bs] = l + 1;
      end else if (l == bl) begin
         f = (f - pool > bf) ? f - pool : bf;
         if (f == bf) drop_at(bpos);
         else slot_last[bs] = f - 1;
      end else begin
         s = claim_slot(l + 1, bl);
         slot_last[bs] = f - 1;
      end
      p_issue = 1'b1;
      p_first = f;
      p_last = l;
      flight_busy = 1'b1;
      s = claim_slot(f, l);
      if (s >= 0) begin
         flight_slot = s;
         flight_held = 1'b1;
      end
   endfunction

   function automatic void cancel_and_reschedule();
      int     pos;
      longint f;
      longint l;
      if (flight_busy) begin
         p_cancel = 1'b1;
         flight_busy = 1'b0;
         if (flight_held) begin
            pos = find_age(flight_slot);
            f = slot_first[flight_slot];
            l = slot_last[flight_slot];
            if (pos >= 0) drop_at(pos);
            flight_held = 1'b0;
            merge_range(f, l);
         end
      end
      pick_batch();
   endfunction

   function automatic void apply_insert(longint from, longint amount);
      bit hit;
      int s;
      hit = 1'b0;
      for (int p = 0; p < age_count; p++) begin
         s = age_order[p];
         if (slot_first[s] >= from) begin
            if (flight_held && s == flight_slot) hit = 1'b1;
            slot_first[s] = (slot_first[s] + amount > IndexTop) ? IndexTop
                                                                 : slot_first[s] + amount;
            slot_last[s] = (slot_last[s] + amount > IndexTop) ? IndexTop
                                                               : slot_last[s] + amount;
         end else if (slot_last[s] >= from) begin
            if (flight_held && s == flight_slot) hit = 1'b1;
            slot_last[s] = (slot_last[s] + amount > IndexTop) ? IndexTop
                                                               : slot_last[s] + amount;
         end
      end
      if (hit) cancel_and_reschedule();
   endfunction

   function automatic void apply_remove(longint from, longint amount);
      bit     hit;
      int     s;
      int     p;
      longint stop;
      hit = 1'b0;
      stop = from + amount;
      p = 0;
      while (p < age_count) begin
         s = age_order[p];
         if (slot_first[s] >= from) begin
            if (flight_held && s == flight_slot) hit = 1'b1;
            if (slot_first[s] >= stop) begin
               slot_first[s] -= amount;
               slot_last[s] -= amount;
               p++;
            end else if (slot_last[s] < stop) begin
               drop_at(p);
            end else begin
               slot_first[s] = from;
               slot_last[s] -= amount;
               p++;
            end
         end else begin
            if (slot_last[s] >= stop) begin
               if (flight_held && s == flight_slot) hit = 1'b1;
               slot_last[s] -= amount;
            end else if (slot_last[s] >= from) begin
               if (flight_held && s == flight_slot) hit = 1'b1;
               slot_last[s] = from - 1;
            end
            p++;
         end
      end
      if (hit) cancel_and_reschedule();
   endfunction

   function automatic fetch_word_type predict_fetch(event_word_type ev);
      fetch_word_type r;
      longint      rl;
      longint      fi;
      int          pos;
      p_issue = 1'b0;
      p_cancel = 1'b0;
      p_full = 1'b0;
      p_first = 0;
      p_last = 0;
      case (ev.func)
         rfs_pkg::FuncRequest: begin
            rl = ev.range_last;
            if (rl < 0 || rl >= longint'(ev.list_size)) rl = longint'(ev.list_size) - 1;
            if (rl >= longint'(ev.range_first)) begin
               merge_range(ev.range_first, rl);
               if (!flight_busy) pick_batch();
            end
         end
         rfs_pkg::FuncComplete: begin
            if (flight_busy) begin
               flight_busy = 1'b0;
               if (flight_held) begin
                  pos = find_age(flight_slot);
                  if (pos >= 0) drop_at(pos);
                  flight_held = 1'b0;
               end
               pick_batch();
            end
         end
         rfs_pkg::FuncInsert: apply_insert(ev.edit_start, ev.edit_count);
         rfs_pkg::FuncRemove: apply_remove(ev.edit_start, ev.edit_count);
         rfs_pkg::FuncFocus: begin
            fi = longint'(ev.scroll_position) / rfs_pkg::ItemHeight;
            focus = (fi > IndexTop) ? IndexTop : fi;
         end
         default: ;
      endcase
      r.fetch_issue = p_issue;
      r.fetch_first = p_issue ? p_first[15:0] : 16'd0;
      r.fetch_last = p_issue ? p_last[15:0] : 16'd0;
      r.fetch_cancel = p_cancel;
      r.table_full = p_full;
      return r;
   endfunction

   function automatic event_word_type random_event();
      event_word_type ev;
      int          pick;
      int          mode;
      longint      l;
      ev = '0;
      pick = $urandom_range(0, 99);
      if (pick < 40) ev.func = rfs_pkg::FuncRequest;
      else if (pick < 58) ev.func = rfs_pkg::FuncComplete;
      else if (pick < 70) ev.func = rfs_pkg::FuncInsert;
      else if (pick < 82) ev.func = rfs_pkg::FuncRemove;
      else if (pick < 92) ev.func = rfs_pkg::FuncFocus;
      else ev.func = 3'($urandom_range(5, 7));
      mode = $urandom_range(0, 9);
      if (mode < 7) ev.range_first = 16'($urandom_range(0, 40) * 50 + $urandom_range(0, 49));
      else ev.range_first = 16'($urandom);
      if (mode < 7) begin
         l = longint'(ev.range_first) + $urandom_range(0, 200);
         ev.range_last = (l > IndexTop) ? 17'(IndexTop) : 17'(l);
      end else if (mode == 7) ev.range_last = -17'sd1;
      else if (mode == 8) ev.range_last = 17'($urandom);
      else ev.range_last = 17'($urandom_range(0, 65535));
      ev.list_size = ($urandom_range(0, 9) < 7) ? 16'hFFFF : 16'($urandom);
      ev.edit_start = ($urandom_range(0, 9) < 8) ? 16'($urandom_range(0, 2100)) : 16'($urandom);
      ev.edit_count = ($urandom_range(0, 9) < 8) ? 16'($urandom_range(0, 60)) : 16'($urandom);
      ev.scroll_position = ($urandom_range(0, 9) < 8) ? 22'($urandom_range(0, 140000))
                                                      : 22'($urandom);
      return ev;
   endfunction

   function automatic event_word_type mk(logic [2:0] f, logic [15:0] rf,
                                         logic signed [16:0] rl, logic [15:0] sz,
                                         logic [15:0] es, logic [15:0] ec, logic [21:0] sp);
      event_word_type ev;
      ev.func = f;
      ev.range_first = rf;
      ev.range_last = rl;
      ev.list_size = sz;
      ev.edit_start = es;
      ev.edit_count = ec;
      ev.scroll_position = sp;
      return ev;
   endfunction

   task automatic send_event(event_word_type ev, bit known, fetch_word_type res);
      int             gap;
      fetch_word_type p;
      gap = $urandom_range(0, 8);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.func <= ev.func;
      req_ch.range_first <= ev.range_first;
      req_ch.range_last <= ev.range_last;
      req_ch.list_size <= ev.list_size;
      req_ch.edit_start <= ev.edit_start;
      req_ch.edit_count <= ev.edit_count;
      req_ch.scroll_position <= ev.scroll_position;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
      p = predict_fetch(ev);
      expected_fetches.push_back(known ? res : p);
   endtask

   task automatic write_batch(int value);
      wait (expected_fetches.size() == 0);
      repeat (100) @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= 3'd0;
      pwdata <= 32'(value);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      batch_len = value & 32'h7FF;
   endtask

   // Result side: random stalls, plus one long hold-off that backs the block up.
   initial begin
      int n;
      int taken;
      taken = 0;
      long_hold_done = 1'b0;
      rsp_ch.ready <= 1'b0;
      @(negedge reset);
      forever begin
         n = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
         if (taken == 200 && !long_hold_done) begin
            n = 400;
            long_hold_done = 1'b1;
         end
         if (taken > 600 && taken < 700) n = 0;
         if (n > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid && rsp_ch.ready));
         taken++;
      end
   end

   always @(posedge clock) begin
      fetch_word_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_fetches.size() == 0) begin
            $error("result word with nothing expected");
            err_count++;
         end else begin
            want = expected_fetches.pop_front();
            if (rsp_ch.fetch_issue !== want.fetch_issue) begin
               $error("fetch_issue: expected %0d, got %0d", want.fetch_issue,
                      rsp_ch.fetch_issue);
               err_count++;
            end
            if (rsp_ch.fetch_first !== want.fetch_first) begin
               $error("fetch_first: expected %0d, got %0d", want.fetch_first,
                      rsp_ch.fetch_first);
               err_count++;
            end
            if (rsp_ch.fetch_last !== want.fetch_last) begin
               $error("fetch_last: expected %0d, got %0d", want.fetch_last,
                      rsp_ch.fetch_last);
               err_count++;
            end
            if (rsp_ch.fetch_cancel !== want.fetch_cancel) begin
               $error("fetch_cancel: expected %0d, got %0d", want.fetch_cancel,
                      rsp_ch.fetch_cancel);
               err_count++;
            end
            if (rsp_ch.table_full !== want.table_full) begin
               $error("table_full: expected %0d, got %0d", want.table_full,
                      rsp_ch.table_full);
               err_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      stim_row_type   rows [$];
      stim_row_type   row;
      fetch_word_type zero_res;
      int             settings [5];
      zero_res = '0;
      settings = '{1, 1024, 0, 37, 1024};
      err_count = 0;
      idle_cycles = 0;
      reset <= 1'b1;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= 3'd0;
      pwdata <= 32'd0;
      req_ch.valid <= 1'b0;
      req_ch.func <= rfs_pkg::FuncRequest;
      req_ch.range_first <= '0;
      req_ch.range_last <= '0;
      req_ch.list_size <= '0;
      req_ch.edit_start <= '0;
      req_ch.edit_count <= '0;
      req_ch.scroll_position <= '0;
      for (int s = 0; s < rfs_pkg::MaxRanges; s++) begin
         slot_valid[s] = 1'b0;
         slot_first[s] = 0;
         slot_last[s] = 0;
         age_order[s] = 0;
      end
      age_count = 0;
      flight_slot = 0;
      flight_held = 1'b0;
      flight_busy = 1'b0;
      focus = 0;
      batch_len = rfs_pkg::BatchReset;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part: known results where obvious, the predictor elsewhere.
      rows.push_back('{mk(rfs_pkg::FuncRequest, 0, 9, 100, 0, 0, 0), 1'b1,
                       '{1'b1, 16'd0, 16'd9, 1'b0, 1'b0}});
      rows.push_back('{mk(rfs_pkg::FuncComplete, 0, 0, 0, 0, 0, 0), 1'b1, zero_res});
      rows.push_back('{mk(rfs_pkg::FuncComplete, 0, 0, 0, 0, 0, 0), 1'b1, zero_res});
      rows.push_back('{mk(3'd5, 16'hFFFF, -17'sd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 22'h3FFFFF),
                       1'b1, zero_res});
      rows.push_back('{mk(3'd6, 0, 0, 0, 0, 0, 0), 1'b1, zero_res});
      rows.push_back('{mk(3'd7, 0, 0, 0, 0, 0, 0), 1'b1, zero_res});
      rows.push_back('{mk(rfs_pkg::FuncRequest, 5, -17'sd1, 3, 0, 0, 0), 1'b1, zero_res});
      rows.push_back('{mk(rfs_pkg::FuncRequest, 16'hFFFF, 17'sd65535, 0, 0, 0, 0), 1'b1,
                       zero_res});
      rows.push_back('{mk(rfs_pkg::FuncFocus, 0, 0, 0, 0, 0, 22'h3FFFFF), 1'b1, zero_res});
      rows.push_back('{mk(rfs_pkg::FuncRequest, 0, -17'sd1, 16'hFFFF, 0, 0, 0), 1'b0, zero_res});
      rows.push_back('{mk(rfs_pkg::FuncRequest, 100, 200, 16'hFFFF, 0, 0, 0), 1'b0, zero_res});
      rows.push_back('{mk(rfs_pkg::FuncRequest, 300, 400, 16'hFFFF, 0, 0, 0), 1'b0, zero_res});
      rows.push_back('{mk(rfs_pkg::FuncRequest, 320, 330, 16'hFFFF, 0, 0, 0), 1'b0, zero_res});
      rows.push_back('{mk(rfs_pkg::FuncInsert, 0, 0, 0, 60000, 0, 0), 1'b0, zero_res});
      rows.push_back('{mk(rfs_pkg::FuncInsert, 0, 0, 0, 0, 16'hFFFF, 0), 1'b0, zero_res});
      rows.push_back('{mk(rfs_pkg::FuncRemove, 0, 0, 0, 500, 0, 0), 1'b0, zero_res});
      rows.push_back('{mk(rfs_pkg::FuncRemove, 0, 0, 0, 0, 16'hFFFF, 0), 1'b0, zero_res});
      rows.push_back('{mk(rfs_pkg::FuncFocus, 0, 0, 0, 0, 0, 7000), 1'b0, zero_res});
      rows.push_back('{mk(rfs_pkg::FuncRequest, 0, 1000, 16'hFFFF, 0, 0, 0), 1'b0, zero_res});
      rows.push_back('{mk(rfs_pkg::FuncRequest, 1200, 1300, 16'hFFFF, 0, 0, 0), 1'b0,
                       zero_res});
      rows.push_back('{mk(rfs_pkg::FuncRemove, 0, 0, 0, 50, 20, 0), 1'b0, zero_res});
      rows.push_back('{mk(rfs_pkg::FuncInsert, 0, 0, 0, 1150, 30, 0), 1'b0, zero_res});
      rows.push_back('{mk(rfs_pkg::FuncComplete, 0, 0, 0, 0, 0, 0), 1'b0, zero_res});
      rows.push_back('{mk(rfs_pkg::FuncFocus, 0, 0, 0, 0, 0, 0), 1'b0, zero_res});
      foreach (rows[i]) begin
         row = rows[i];
         send_event(row.ev, row.known, row.res);
      end
      for (int k = 0; k < RunsOfRandom; k++) send_event(random_event(), 1'b0, zero_res);
      foreach (settings[i]) begin
         req_ch.valid <= 1'b0;
         write_batch(settings[i]);
         for (int k = 0; k < RunsOfRandom - 60; k++) send_event(random_event(), 1'b0, zero_res);
      end
      req_ch.valid <= 1'b0;
      wait (expected_fetches.size() == 0);
      repeat (100) @(posedge clock);
      if (err_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
